// File: sv/bsd_pkg.sv
`default_nettype none
package bsd_pkg;

  localparam int COORD_W = 32;
  localparam int AXES    = 3;
  localparam int SQ_W    = 2 * (COORD_W - 1);
  localparam int SUM_W   = 2 * COORD_W;
  localparam int ROOT_W  = COORD_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int IDX_W   = 3;

  localparam logic signed [COORD_W-1:0] DIST_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  localparam logic [IDX_W-1:0] REG_LOW_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HIGH_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_LOW_Y  = 3'd2;
  localparam logic [IDX_W-1:0] REG_HIGH_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_LOW_Z  = 3'd4;
  localparam logic [IDX_W-1:0] REG_HIGH_Z = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] distance;
    logic                      saturated;
  } out_t;

  typedef struct packed {
    coord_t [AXES-1:0] lo;
    coord_t [AXES-1:0] hi;
  } box_t;

  typedef struct packed {
    logic   in_box;
    logic   sat;
    coord_t dist_in;
  } meta_t;

endpackage
`default_nettype wire

// File: sv/bsd_front.sv
`default_nettype none
module bsd_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire bsd_pkg::box_t          box,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire bsd_pkg::in_t           in_data,
  output logic                        s_valid,
  input  wire                         s_ready,
  output logic [bsd_pkg::SUM_W-1:0]   s_sum,
  output bsd_pkg::meta_t              s_meta
);
  import bsd_pkg::*;

  coord_t                    p [AXES];
  logic signed [COORD_W:0]   d_lo [AXES];
  logic signed [COORD_W:0]   d_hi [AXES];
  logic signed [COORD_W:0]   inner [AXES];
  logic [COORD_W-1:0]        gap [AXES];
  logic [AXES-1:0]           in_ax;
  logic [AXES-1:0]           big_ax;

  logic                      v1_r, v2_r, v3_r;
  logic                      r1, r2, r3;
  coord_t                    inner1_r [AXES];
  logic [COORD_W-2:0]        gap1_r [AXES];
  logic                      in_box1_r, sat1_r;
  logic [SQ_W-1:0]           sq2_r [AXES];
  meta_t                     meta2_r, meta3_r;
  coord_t                    max01, max_nxt;
  logic [SUM_W-1:0]          sum3_r;

  always_comb begin
    p[0] = in_data.point_x;
    p[1] = in_data.point_y;
    p[2] = in_data.point_z;
    for (int a = 0; a < AXES; a++) begin
      d_lo[a]   = {box.lo[a][COORD_W-1], box.lo[a]} - {p[a][COORD_W-1], p[a]};
      d_hi[a]   = {p[a][COORD_W-1], p[a]} - {box.hi[a][COORD_W-1], box.hi[a]};
      inner[a]  = (d_lo[a] > d_hi[a]) ? d_lo[a] : d_hi[a];
      in_ax[a]  = d_lo[a][COORD_W] && d_hi[a][COORD_W];
      gap[a]    = inner[a][COORD_W] ? '0 : inner[a][COORD_W-1:0];
      big_ax[a] = gap[a][COORD_W-1];
    end
  end

  assign r3       = !v3_r || s_ready;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (r1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      for (int a = 0; a < AXES; a++) begin
        inner1_r[a] <= inner[a][COORD_W-1:0];
        gap1_r[a]   <= gap[a][COORD_W-2:0];
      end
      in_box1_r <= &in_ax;
      sat1_r    <= |big_ax;
    end
  end

  always_comb begin
    max01   = (inner1_r[0] > inner1_r[1]) ? inner1_r[0] : inner1_r[1];
    max_nxt = (max01 > inner1_r[2]) ? max01 : inner1_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (r2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1_r) begin
      for (int a = 0; a < AXES; a++) begin
        sq2_r[a] <= gap1_r[a] * gap1_r[a];
      end
      meta2_r.in_box  <= in_box1_r;
      meta2_r.sat     <= sat1_r;
      meta2_r.dist_in <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (r3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r3 && v2_r) begin
      sum3_r  <= SUM_W'(sq2_r[0]) + SUM_W'(sq2_r[1]) + SUM_W'(sq2_r[2]);
      meta3_r <= meta2_r;
    end
  end

  assign s_valid = v3_r;
  assign s_sum   = sum3_r;
  assign s_meta  = meta3_r;

endmodule
`default_nettype wire

// File: sv/bsd_sqrt.sv
`default_nettype none
module bsd_sqrt (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [bsd_pkg::SUM_W-1:0]     in_sum,
  input  wire bsd_pkg::meta_t          in_meta,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [bsd_pkg::ROOT_W-1:0]   out_root,
  output bsd_pkg::meta_t               out_meta
);
  import bsd_pkg::*;

  localparam int N = ROOT_W;

  logic [N:0]          vld;
  logic [N+1:1]        rdy;
  logic [SUM_W-1:0]    rad  [N+1];
  logic [REM_W-1:0]    rem  [N+1];
  logic [ROOT_W-1:0]   root [N+1];
  meta_t               meta [N+1];

  assign vld[0]   = in_valid;
  assign rad[0]   = in_sum;
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign meta[0]  = in_meta;
  assign rdy[N+1] = out_ready;
  assign in_ready = rdy[1];

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic               vld_r;
    logic [SUM_W-1:0]   rad_r;
    logic [REM_W-1:0]   rem_r;
    logic [ROOT_W-1:0]  root_r;
    meta_t              meta_r;
    logic [REM_W-1:0]   rem_sh, trial, rem_nxt;
    logic               ge;

    always_comb begin
      rem_sh  = {rem[k-1][REM_W-3:0], rad[k-1][SUM_W-1 -: 2]};
      trial   = {1'b0, root[k-1], 2'b01};
      ge      = rem_sh >= trial;
      rem_nxt = ge ? rem_sh - trial : rem_sh;
    end

    assign rdy[k] = !vld_r || rdy[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[k]) begin
        vld_r <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        rad_r  <= {rad[k-1][SUM_W-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= {root[k-1][ROOT_W-2:0], ge};
        meta_r <= meta[k-1];
      end
    end

    assign vld[k]  = vld_r;
    assign rad[k]  = rad_r;
    assign rem[k]  = rem_r;
    assign root[k] = root_r;
    assign meta[k] = meta_r;
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_meta  = meta[N];

endmodule
`default_nettype wire

// File: sv/box_signed_distance.sv
// Channel  Ports                           Width  Transfer when
// input    in_valid in_ready in_data       96     in_valid && in_ready
// result   out_valid out_ready out_data    33     out_valid && out_ready
// config   cfg_we cfg_index cfg_data       3/32   cfg_we high
//
// One point per cycle sustained while out_ready stays high; 36 register stages:
// three stages of gap, square and sum, 32 square-root stages (one root bit each),
// and the output register.
// Synchronous active-low reset empties every stage and clears the bounds to zero.
// A stalled output stage holds; stages behind it keep filling empty slots.
`default_nettype none
module box_signed_distance (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire bsd_pkg::in_t            in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output bsd_pkg::out_t                out_data,
  input  wire                          cfg_we,
  input  wire [bsd_pkg::IDX_W-1:0]     cfg_index,
  input  wire [bsd_pkg::COORD_W-1:0]   cfg_data
);
  import bsd_pkg::*;

  box_t                box_r, box_nxt;
  logic                s_valid, s_ready;
  logic [SUM_W-1:0]    s_sum;
  meta_t               s_meta;
  logic                q_valid, q_ready;
  logic [ROOT_W-1:0]   q_root;
  meta_t               q_meta;
  logic                out_valid_r;
  out_t                out_r, out_nxt;
  logic                clamp;

  always_comb begin
    box_nxt = box_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW_X:  box_nxt.lo[0] = cfg_data;
        REG_HIGH_X: box_nxt.hi[0] = cfg_data;
        REG_LOW_Y:  box_nxt.lo[1] = cfg_data;
        REG_HIGH_Y: box_nxt.hi[1] = cfg_data;
        REG_LOW_Z:  box_nxt.lo[2] = cfg_data;
        REG_HIGH_Z: box_nxt.hi[2] = cfg_data;
        default:    box_nxt = box_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= '0;
    end else begin
      box_r <= box_nxt;
    end
  end

  bsd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .box      (box_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_sum    (s_sum),
    .s_meta   (s_meta)
  );

  bsd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_sum    (s_sum),
    .in_meta   (s_meta),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_root  (q_root),
    .out_meta  (q_meta)
  );

  // clamp outside distances that do not fit the signed range
  always_comb begin
    clamp = q_meta.sat || q_root[ROOT_W-1];
    if (q_meta.in_box) begin
      out_nxt.distance  = q_meta.dist_in;
      out_nxt.saturated = 1'b0;
    end else if (clamp) begin
      out_nxt.distance  = DIST_MAX;
      out_nxt.saturated = 1'b1;
    end else begin
      out_nxt.distance  = coord_t'(q_root);
      out_nxt.saturated = 1'b0;
    end
  end

  assign q_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_ready && q_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |-> out_data.distance == DIST_MAX)
    else $error("saturated result without maximum distance");

  a_neg_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.distance[COORD_W-1] |-> !out_data.saturated)
    else $error("negative distance flagged saturated");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
